// ===== design/lrmp_pkg.sv =====
package lrmp_pkg;

  localparam int VAL_BITS = 30;
  localparam logic [VAL_BITS-1:0] MODULUS = 30'd1000000007;

  localparam logic [VAL_BITS-1:0] RST_COEF_PREV      = 30'd1;
  localparam logic [VAL_BITS-1:0] RST_COEF_PREV_PREV = 30'd2;
  localparam logic [VAL_BITS-1:0] RST_FIRST_TERM     = 30'd1;
  localparam logic [VAL_BITS-1:0] RST_SECOND_TERM    = 30'd6;

  localparam logic [1:0] REG_COEF_PREV      = 2'd0;
  localparam logic [1:0] REG_COEF_PREV_PREV = 2'd1;
  localparam logic [1:0] REG_FIRST_TERM     = 2'd2;
  localparam logic [1:0] REG_SECOND_TERM    = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_WAIT,
    ST_BIT_DONE,
    ST_DONE
  } state_t;

  // Request to the modular multiply-add unit: (a*b + c*d) mod P.
  typedef struct packed {
    logic                start;
    logic [VAL_BITS-1:0] a;
    logic [VAL_BITS-1:0] b;
    logic [VAL_BITS-1:0] c;
    logic [VAL_BITS-1:0] d;
  } mac_req_t;

  // Reduce a value below 2^30 to below P (one subtract is enough).
  function automatic logic [VAL_BITS-1:0] red(input logic [VAL_BITS-1:0] v);
    logic [VAL_BITS-1:0] r;
    r = (v >= MODULUS) ? v - MODULUS : v;
    return r;
  endfunction

endpackage

// ===== design/lrmp_mac.sv =====
// Bit-serial modular multiply-add: res = (a*b + c*d) mod P.
// Scans the multipliers b and d MSB first, one bit per cycle, with a
// doubling accumulator kept below P.
module lrmp_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  lrmp_pkg::mac_req_t           req,
  output logic                         done,
  output logic [lrmp_pkg::VAL_BITS-1:0] res
);

  localparam int W = lrmp_pkg::VAL_BITS;

  logic [W-1:0]         a_r, c_r, b_sh, d_sh, acc;
  logic [4:0]           cnt;
  logic                 busy;
  logic [W+1:0]         dbl, s1, s2;
  logic [W-1:0]         acc_next;

  // Double, then add a and c as selected by the current bits, reducing each step.
  always_comb begin
    dbl = {2'b00, acc} << 1;
    if (dbl >= {2'b00, lrmp_pkg::MODULUS}) dbl = dbl - {2'b00, lrmp_pkg::MODULUS};
    s1 = dbl + (b_sh[W-1] ? {2'b00, a_r} : '0);
    if (s1 >= {2'b00, lrmp_pkg::MODULUS}) s1 = s1 - {2'b00, lrmp_pkg::MODULUS};
    s2 = s1 + (d_sh[W-1] ? {2'b00, c_r} : '0);
    if (s2 >= {2'b00, lrmp_pkg::MODULUS}) s2 = s2 - {2'b00, lrmp_pkg::MODULUS};
    acc_next = s2[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == '0) busy <= 1'b0;
      end
    end
  end

  // Load operands, then shift the multiplier bits out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_sh <= req.b;
      c_r  <= req.c;
      d_sh <= req.d;
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh << 1;
      d_sh <= d_sh << 1;
    end
  end

  assign res = acc;

endmodule

// ===== design/linear_recurrence_matrix_power_mod_unit.sv =====
// Returns term n of f(n) = coef_prev*f(n-1) + coef_prev_prev*f(n-2) mod 1000000007,
// with f(1) = first_term and f(2) = second_term (registers 0..3 of the write port).
// Index 0 gives 0, indexes 1 and 2 give the stored terms via the setup and done
// states after acceptance. Larger indexes raise the companion matrix to n-2 by
// square-and-multiply over INDEX_BITS exponent bits; every modular product runs
// through one bit-serial multiply-add unit. Each exponent bit takes four products
// for the square plus four more when the bit is set, each group of four ending in
// a matrix update, and one final product forms the result word. One item is in
// flight at a time; the result word waits in an output register and the next
// index is taken once it has been delivered.
module linear_recurrence_matrix_power_mod_unit #(
  parameter int INDEX_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [lrmp_pkg::VAL_BITS-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [INDEX_BITS-1:0]          index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lrmp_pkg::VAL_BITS-1:0]  term_value
);

  localparam int W  = lrmp_pkg::VAL_BITS;
  localparam int BW = $clog2(INDEX_BITS + 1);

  lrmp_pkg::state_t state, state_next;

  logic [W-1:0] coef_prev, coef_prev_prev, first_term, second_term;
  logic [INDEX_BITS-1:0] expo;
  logic [BW-1:0]         bit_cnt;
  // Matrices: base b00..b11 and accumulator m00..m11, plus scratch results.
  logic [W-1:0] b00, b01, b10, b11, m00, m01, m10, m11;
  logic [W-1:0] t0, t1, t2, t3;
  logic [3:0]   op;         // product number within a bit step (0..7), 8 = final
  logic         out_full;
  logic [W-1:0] out_r;

  lrmp_pkg::mac_req_t req;
  logic               mac_done;
  logic [W-1:0]       mac_res;

  lrmp_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (mac_done),
    .res  (mac_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_prev      <= lrmp_pkg::RST_COEF_PREV;
      coef_prev_prev <= lrmp_pkg::RST_COEF_PREV_PREV;
      first_term     <= lrmp_pkg::RST_FIRST_TERM;
      second_term    <= lrmp_pkg::RST_SECOND_TERM;
    end else if (cfg_we) begin
      case (cfg_index)
        lrmp_pkg::REG_COEF_PREV:      coef_prev      <= cfg_data;
        lrmp_pkg::REG_COEF_PREV_PREV: coef_prev_prev <= cfg_data;
        lrmp_pkg::REG_FIRST_TERM:     first_term     <= cfg_data;
        lrmp_pkg::REG_SECOND_TERM:    second_term    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready   = (state == lrmp_pkg::ST_IDLE) && !out_full;
  assign out_valid  = out_full;
  assign term_value = out_r;

  logic bit_set;
  assign bit_set = expo[0];

  // Skip the multiply products when the exponent bit is clear.
  logic [3:0] op_eff;
  assign op_eff = (op == 4'd0 && !bit_set) ? 4'd4 : op;

  // Next state and multiply requests.
  always_comb begin
    state_next = state;
    req        = '0;
    case (state)
      lrmp_pkg::ST_IDLE:
        if (in_valid && in_ready) state_next = lrmp_pkg::ST_SETUP;
      lrmp_pkg::ST_SETUP:
        state_next = (expo == '0 || expo == INDEX_BITS'(1) || expo == INDEX_BITS'(2)) ?
                     lrmp_pkg::ST_DONE : lrmp_pkg::ST_ISSUE;
      lrmp_pkg::ST_ISSUE: begin
        req.start = 1'b1;
        case (op_eff)
          // Products for acc*base (only when the bit is set).
          4'd0: begin req.a = m00; req.b = b00; req.c = m01; req.d = b10; end
          4'd1: begin req.a = m00; req.b = b01; req.c = m01; req.d = b11; end
          4'd2: begin req.a = m10; req.b = b00; req.c = m11; req.d = b10; end
          4'd3: begin req.a = m10; req.b = b01; req.c = m11; req.d = b11; end
          // Products for base*base.
          4'd4: begin req.a = b00; req.b = b00; req.c = b01; req.d = b10; end
          4'd5: begin req.a = b00; req.b = b01; req.c = b01; req.d = b11; end
          4'd6: begin req.a = b10; req.b = b00; req.c = b11; req.d = b10; end
          4'd7: begin req.a = b10; req.b = b01; req.c = b11; req.d = b11; end
          default: begin
            req.a = m10; req.b = lrmp_pkg::red(first_term);
            req.c = m11; req.d = lrmp_pkg::red(second_term);
          end
        endcase
        state_next = lrmp_pkg::ST_WAIT;
      end
      lrmp_pkg::ST_WAIT:
        if (mac_done) begin
          if (op == 4'd8) state_next = lrmp_pkg::ST_DONE;
          else if (op == 4'd3 || op == 4'd7) state_next = lrmp_pkg::ST_BIT_DONE;
          else state_next = lrmp_pkg::ST_ISSUE;
        end
      lrmp_pkg::ST_BIT_DONE:
        state_next = lrmp_pkg::ST_ISSUE;
      lrmp_pkg::ST_DONE:
        state_next = lrmp_pkg::ST_IDLE;
      default: state_next = lrmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lrmp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else begin
      if (out_full && out_ready) out_full <= 1'b0;
      case (state)
        lrmp_pkg::ST_IDLE:
          if (in_valid && in_ready) expo <= index;
        lrmp_pkg::ST_SETUP: begin
          b00 <= '0;  b01 <= W'(1);
          b10 <= lrmp_pkg::red(coef_prev_prev);
          b11 <= lrmp_pkg::red(coef_prev);
          m00 <= W'(1); m01 <= '0; m10 <= '0; m11 <= W'(1);
          bit_cnt <= '0;
          if (expo == '0)                  out_r <= '0;
          else if (expo == INDEX_BITS'(1)) out_r <= lrmp_pkg::red(first_term);
          else if (expo == INDEX_BITS'(2)) out_r <= lrmp_pkg::red(second_term);
          expo <= expo - INDEX_BITS'(2);
          op   <= 4'd0;
        end
        lrmp_pkg::ST_ISSUE:
          // Track the product actually issued.
          op <= op_eff;
        lrmp_pkg::ST_WAIT:
          if (mac_done) begin
            case (op)
              4'd0, 4'd4: t0 <= mac_res;
              4'd1, 4'd5: t1 <= mac_res;
              4'd2, 4'd6: t2 <= mac_res;
              4'd3, 4'd7: t3 <= mac_res;
              default:    out_r <= mac_res;
            endcase
            if (op != 4'd3 && op != 4'd7) op <= op + 4'd1;
          end
        lrmp_pkg::ST_BIT_DONE:
          if (op == 4'd3) begin
            m00 <= t0; m01 <= t1; m10 <= t2; m11 <= t3;
            op  <= 4'd4;
          end else begin
            b00 <= t0; b01 <= t1; b10 <= t2; b11 <= t3;
            expo    <= expo >> 1;
            bit_cnt <= bit_cnt + BW'(1);
            op      <= (bit_cnt == BW'(INDEX_BITS - 1)) ? 4'd8 : 4'd0;
          end
        lrmp_pkg::ST_DONE:
          out_full <= 1'b1;
        default: ;
      endcase
    end
  end

  // Output register holds its word until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(term_value))
    else $error("result word changed while stalled");

  // No new index while a result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted with result pending");

  // Results stay below the modulus.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> term_value < lrmp_pkg::MODULUS)
    else $error("result not reduced");

endmodule
